// ----- src/binary_nearest_centroid_accumulate_defines.svh -----
// Assertion macros for the nearest-centroid block.
// Each expects clk and arst_n in the module that uses it.
`ifndef BINARY_NEAREST_CENTROID_ACCUMULATE_DEFINES_SVH
`define BINARY_NEAREST_CENTROID_ACCUMULATE_DEFINES_SVH
`ifndef SYNTHESIS
`define BNCA_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define BNCA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`define BNCA_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");
`else
`define BNCA_ASSERT_SAME(lbl, ante, cons)
`define BNCA_ASSERT_NEXT(lbl, ante, cons)
`define BNCA_ASSERT_ALWAYS(lbl, cond)
`endif
`endif

// ----- src/bnca_pkg.sv -----
package bnca_pkg;
	localparam int NUM_CL   = 16;
	localparam int CL_W     = 4;
	localparam int WORDS    = 4;
	localparam int WORD_W   = 2;
	localparam int LANES    = 64;
	localparam int ROW_W    = CL_W + WORD_W;
	localparam int ROWS     = NUM_CL * WORDS;
	localparam int CVAL_W   = 17;
	localparam int SUM_W    = 24;
	localparam int DIST_W   = 41;
	localparam int ACC_W    = 43;
	localparam int CSUM_W   = 23;
	localparam int GRP      = 8;
	localparam int GRP_W    = 20;
	localparam int POP_W    = 7;
	localparam logic [CVAL_W-1:0] ONE_Q16 = 17'd65536;
	localparam logic [SUM_W-1:0]  SUM_MAX = {SUM_W{1'b1}};

	localparam logic [2:0] REQ_LOAD  = 3'd0;
	localparam logic [2:0] REQ_WORD  = 3'd1;
	localparam logic [2:0] REQ_RSUM  = 3'd2;
	localparam logic [2:0] REQ_RCNT  = 3'd3;
	localparam logic [2:0] REQ_CLEAR = 3'd4;

	localparam logic [1:0] KIND_ASSIGN = 2'd0;
	localparam logic [1:0] KIND_SUM    = 2'd1;
	localparam logic [1:0] KIND_COUNT  = 2'd2;

	typedef logic [LANES-1:0][CVAL_W-1:0] crow_t;
	typedef logic [LANES-1:0][SUM_W-1:0]  srow_t;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_LOAD1  = 7'b0000010,
		ST_LOAD2  = 7'b0000100,
		ST_SCORE  = 7'b0001000,
		ST_ACC_RD = 7'b0010000,
		ST_ACC_WR = 7'b0100000,
		ST_RSUM   = 7'b1000000
	} state_t;
endpackage

// ----- src/bnca_lane.sv -----
// One bit position: centroid term for scoring, saturating count for accumulate.
module bnca_lane import bnca_pkg::*; (
	input  logic              bit_in,
	input  logic [CVAL_W-1:0] cval,
	input  logic [SUM_W-1:0]  sum_in,
	output logic [CVAL_W-1:0] cmask,
	output logic [SUM_W-1:0]  sum_out
);
	assign cmask = bit_in ? cval : '0;
	assign sum_out = (bit_in && sum_in != SUM_MAX) ? sum_in + 1'b1 : sum_in;
endmodule

// ----- src/bnca_merge.sv -----
// Two-level adder tree over the lanes; first level registered.
module bnca_merge import bnca_pkg::*; (
	input  logic                          clk,
	input  logic [LANES-1:0][CVAL_W-1:0]  cmask,
	input  logic [LANES-1:0]              bits,
	output logic [CSUM_W-1:0]             csum,
	output logic [POP_W-1:0]              popcnt
);
	logic [GRP-1:0][GRP_W-1:0] grp_s2;
	logic [POP_W-1:0]          pop_s2;

	// group sums of eight lanes and the set-bit count
	always_ff @(posedge clk) begin
		for (int g = 0; g < GRP; g++) begin
			logic [GRP_W-1:0] s;
			s = '0;
			for (int k = 0; k < LANES / GRP; k++)
				s = s + GRP_W'(cmask[g * (LANES / GRP) + k]);
			grp_s2[g] <= s;
		end
		pop_s2 <= POP_W'($countones(bits));
	end

	// final level
	always_comb begin
		csum = '0;
		for (int g = 0; g < GRP; g++)
			csum = csum + CSUM_W'(grp_s2[g]);
	end
	assign popcnt = pop_s2;
endmodule

// ----- src/binary_nearest_centroid_accumulate.sv -----
// Nearest-centroid assignment for 256-bit binary descriptors, 16 clusters.
// A request is taken when start is high and busy is low; a result appears for
// one cycle with result_valid high and cannot be held off. Each descriptor word
// is scored one cluster per cycle through the 64-lane row of the centroid
// memory and then through the pipeline; the last word of a descriptor adds a
// read-modify-write of the winner's four sum rows and then gives the assignment.
// Stores reset through per-row valid bits, so no clearing pass is needed.
`include "binary_nearest_centroid_accumulate_defines.svh"
module binary_nearest_centroid_accumulate import bnca_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [2:0]          req_type,
	input  logic [3:0]          cluster_sel,
	input  logic [7:0]          elem_index,
	input  logic [16:0]         centroid_value,
	input  logic [63:0]         tx_word,
	input  logic                cfg_wr_en,
	input  logic [4:0]          cfg_wr_data,
	output logic                result_valid,
	output logic [1:0]          result_kind,
	output logic [3:0]          cluster_index,
	output logic [40:0]         distance,
	output logic [23:0]         read_value
);
	state_t state_q;
	logic [4:0] active_q;

	logic [CL_W-1:0]   sel_q;
	logic [5:0]        lane_q;
	logic [CVAL_W-1:0] cval_q;
	logic [LANES-1:0]  buf_q [WORDS];
	logic [WORD_W-1:0] wc_q;
	logic [4:0]        issue_q;
	logic              v_s1, v_s2;
	logic [CL_W-1:0]   j_s1, j_s2;
	logic [CL_W-1:0]   best_q;
	logic [DIST_W-1:0] bestd_q;
	logic [WORD_W-1:0] accw_q;
	logic [ACC_W-1:0]  part_q [NUM_CL];
	logic [DIST_W-1:0] norm_q [NUM_CL];
	logic [SUM_W-1:0]  cnt_q [NUM_CL];
	logic [33:0]       sq_old_q, sq_new_q;

	// centroid and sum memories, one row = 64 bit positions of one word
	crow_t cmem [ROWS];
	srow_t smem [ROWS];
	crow_t cdata_q;
	srow_t sdata_q;
	logic [ROWS-1:0] cvalid_q, svalid_q;
	logic crow_ok_q, srow_ok_q;
	logic [ROW_W-1:0] c_raddr, s_raddr;

	logic accept;
	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);

	logic addr_ok;
	assign addr_ok = {1'b0, cluster_sel} < active_q;

	// read address selection
	always_comb begin
		c_raddr = {issue_q[CL_W-1:0], wc_q};
		if (state_q == ST_IDLE)
			c_raddr = {cluster_sel, elem_index[7:6]};
		s_raddr = {best_q, accw_q};
		if (state_q == ST_IDLE)
			s_raddr = {cluster_sel, elem_index[7:6]};
	end

	always_ff @(posedge clk) begin
		cdata_q <= cmem[c_raddr];
		sdata_q <= smem[s_raddr];
	end

	// lanes
	logic [LANES-1:0] bits_sel, bits_lane;
	crow_t cval_lane, cmask;
	srow_t sum_lane, sum_new;
	assign bits_sel = (state_q == ST_SCORE) ? buf_q[wc_q] : buf_q[accw_q];

	for (genvar p = 0; p < LANES; p++) begin : g_lane
		assign bits_lane[p] = bits_sel[LANES-1-p];
		assign cval_lane[p] = crow_ok_q ? cdata_q[p] : '0;
		assign sum_lane[p]  = srow_ok_q ? sdata_q[p] : '0;
		bnca_lane u_lane (
			.bit_in (bits_lane[p]),
			.cval   (cval_lane[p]),
			.sum_in (sum_lane[p]),
			.cmask  (cmask[p]),
			.sum_out(sum_new[p])
		);
	end

	logic [CSUM_W-1:0] csum;
	logic [POP_W-1:0]  popcnt;
	bnca_merge u_merge (
		.clk   (clk),
		.cmask (cmask),
		.bits  (bits_lane),
		.csum  (csum),
		.popcnt(popcnt)
	);

	// cluster score: base plus n*2^32 - 2^17*sum(c)
	logic [CL_W-1:0]   norm_idx;
	logic [ACC_W-1:0]  base, acc_new;
	logic [DIST_W-1:0] du;
	assign norm_idx = (state_q == ST_LOAD2) ? sel_q : j_s2;
	always_comb begin
		base = (wc_q == '0) ? {2'b00, norm_q[norm_idx]} : part_q[j_s2];
		acc_new = base + {4'b0, popcnt, 32'b0} - {3'b0, csum, 17'b0};
		if (acc_new[ACC_W-1])
			du = '0;
		else if (acc_new[ACC_W-2:DIST_W] != '0)
			du = '1;
		else
			du = acc_new[DIST_W-1:0];
	end

	// old centroid element of a load
	logic [CVAL_W-1:0] old_c;
	crow_t c_wrow;
	always_comb begin
		old_c = cval_lane[lane_q];
		c_wrow = cval_lane;
		c_wrow[lane_q] = cval_q;
	end

	logic [CL_W-1:0] cnt_idx;
	assign cnt_idx = (state_q == ST_IDLE) ? cluster_sel : best_q;

	// memory writes
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD1)
			cmem[{sel_q, accw_q}] <= c_wrow;
		if (state_q == ST_ACC_WR)
			smem[{best_q, accw_q}] <= sum_new;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sel_q  <= cluster_sel;
			lane_q <= elem_index[5:0];
			accw_q <= elem_index[7:6];
			cval_q <= (centroid_value > ONE_Q16) ? ONE_Q16 : centroid_value;
			if (req_type == REQ_WORD)
				buf_q[wc_q] <= tx_word;
		end
		if (state_q == ST_LOAD1) begin
			sq_old_q <= old_c * old_c;
			sq_new_q <= cval_q * cval_q;
		end
		if (v_s2)
			part_q[j_s2] <= acc_new;
		if (state_q == ST_ACC_WR && accw_q != WORD_W'(WORDS - 1))
			accw_q <= accw_q + 1'b1;
		if (state_q == ST_SCORE && v_s2 && j_s2 == CL_W'(NUM_CL - 1) &&
		    wc_q == WORD_W'(WORDS - 1))
			accw_q <= '0;
		if (v_s2 && wc_q == WORD_W'(WORDS - 1) && {1'b0, j_s2} < active_q &&
		    (j_s2 == '0 || du < bestd_q)) begin
			best_q  <= j_s2;
			bestd_q <= du;
		end
		j_s1 <= issue_q[CL_W-1:0];
		j_s2 <= j_s1;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			active_q     <= 5'd16;
			wc_q         <= '0;
			issue_q      <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			cvalid_q     <= '0;
			svalid_q     <= '0;
			crow_ok_q    <= 1'b0;
			srow_ok_q    <= 1'b0;
			result_valid <= 1'b0;
			result_kind  <= KIND_ASSIGN;
			cluster_index <= '0;
			distance     <= '0;
			read_value   <= '0;
			for (int i = 0; i < NUM_CL; i++) begin
				norm_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			result_valid <= 1'b0;
			crow_ok_q <= cvalid_q[c_raddr];
			srow_ok_q <= svalid_q[s_raddr];
			v_s2 <= v_s1;
			v_s1 <= 1'b0;
			if (cfg_wr_en) begin
				if (cfg_wr_data == 5'd0)
					active_q <= 5'd1;
				else if (cfg_wr_data > 5'd16)
					active_q <= 5'd16;
				else
					active_q <= cfg_wr_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						priority if (req_type == REQ_LOAD) begin
							if (addr_ok)
								state_q <= ST_LOAD1;
						end else if (req_type == REQ_WORD) begin
							issue_q <= '0;
							state_q <= ST_SCORE;
						end else if (req_type == REQ_RSUM) begin
							if (addr_ok)
								state_q <= ST_RSUM;
						end else if (req_type == REQ_RCNT) begin
							if (addr_ok) begin
								result_valid  <= 1'b1;
								result_kind   <= KIND_COUNT;
								cluster_index <= cluster_sel;
								distance      <= '0;
								read_value    <= cnt_q[cnt_idx];
							end
						end else if (req_type == REQ_CLEAR) begin
							svalid_q <= '0;
							for (int i = 0; i < NUM_CL; i++)
								cnt_q[i] <= '0;
						end
					end
				end
				ST_LOAD1: begin
					cvalid_q[{sel_q, accw_q}] <= 1'b1;
					state_q <= ST_LOAD2;
				end
				ST_LOAD2: begin
					norm_q[sel_q] <= norm_q[norm_idx] - DIST_W'(sq_old_q) +
						DIST_W'(sq_new_q);
					state_q <= ST_IDLE;
				end
				ST_SCORE: begin
					if (issue_q < 5'(NUM_CL)) begin
						v_s1    <= 1'b1;
						issue_q <= issue_q + 1'b1;
					end
					if (v_s2 && j_s2 == CL_W'(NUM_CL - 1)) begin
						wc_q <= wc_q + 1'b1;
						if (wc_q == WORD_W'(WORDS - 1))
							state_q <= ST_ACC_RD;
						else
							state_q <= ST_IDLE;
					end
				end
				ST_ACC_RD: begin
					state_q <= ST_ACC_WR;
				end
				ST_ACC_WR: begin
					svalid_q[{best_q, accw_q}] <= 1'b1;
					if (accw_q == WORD_W'(WORDS - 1)) begin
						if (cnt_q[cnt_idx] != SUM_MAX)
							cnt_q[cnt_idx] <= cnt_q[cnt_idx] + 1'b1;
						result_valid  <= 1'b1;
						result_kind   <= KIND_ASSIGN;
						cluster_index <= best_q;
						distance      <= bestd_q;
						read_value    <= '0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_ACC_RD;
					end
				end
				ST_RSUM: begin
					result_valid  <= 1'b1;
					result_kind   <= KIND_SUM;
					cluster_index <= sel_q;
					distance      <= '0;
					read_value    <= sum_lane[lane_q];
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`BNCA_ASSERT_ALWAYS(a_state_onehot, $onehot(state_q))
	`BNCA_ASSERT_SAME(a_result_idle, result_valid, state_q == ST_IDLE)
	`BNCA_ASSERT_SAME(a_pipe_in_score, v_s2, state_q == ST_SCORE)
	`BNCA_ASSERT_NEXT(a_assign_out, state_q == ST_ACC_WR && accw_q == WORD_W'(WORDS - 1),
		result_valid && result_kind == KIND_ASSIGN)
endmodule

// ----- verif/tb.sv -----
module tb;
	import bnca_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DBITS = 256;
	localparam logic [40:0] DMAX = {41{1'b1}};

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  idx;
		logic [40:0] dsq;
		logic [23:0] val;
	} outcome_t;

	typedef struct {
		logic [2:0]  req;
		logic [3:0]  sel;
		logic [7:0]  elem;
		logic [16:0] cval;
		logic [63:0] word;
		bit          has_fixed;
		outcome_t    fixed;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  req_type;
	logic [3:0]  cluster_sel;
	logic [7:0]  elem_index;
	logic [16:0] centroid_value;
	logic [63:0] tx_word;
	logic        cfg_wr_en;
	logic [4:0]  cfg_wr_data;
	logic        result_valid;
	logic [1:0]  result_kind;
	logic [3:0]  cluster_index;
	logic [40:0] distance;
	logic [23:0] read_value;

	binary_nearest_centroid_accumulate dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .cluster_sel(cluster_sel), .elem_index(elem_index),
		.centroid_value(centroid_value), .tx_word(tx_word),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.result_valid(result_valid), .result_kind(result_kind),
		.cluster_index(cluster_index), .distance(distance), .read_value(read_value)
	);

	// predictor state
	int unsigned     m_active;
	logic [16:0]     m_cent [NUM_CL*DBITS];
	longint unsigned m_norm [NUM_CL];
	longint          m_part [NUM_CL];
	logic [63:0]     m_desc [WORDS];
	int unsigned     m_wcnt;
	logic [23:0]     m_bsum [NUM_CL*DBITS];
	logic [23:0]     m_cnt  [NUM_CL];

	outcome_t pending_results[$];
	int errors = 0;
	int n_req = 0, n_res = 0, n_assign = 0;

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	initial begin
		#200ms;
		$display("Timeout at %0t", $time);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic void model_reset();
		m_active = 16;
		m_wcnt = 0;
		for (int i = 0; i < NUM_CL*DBITS; i++) begin
			m_cent[i] = '0;
			m_bsum[i] = '0;
		end
		for (int i = 0; i < NUM_CL; i++) begin
			m_norm[i] = 0; m_part[i] = 0; m_cnt[i] = '0;
		end
	endfunction

	function automatic void model_cfg(logic [4:0] v);
		int unsigned x;
		x = 32'(v);
		if (x == 0) x = 1;
		if (x > NUM_CL) x = NUM_CL;
		m_active = x;
	endfunction

	// computes the nearest-centroid outcome of one request; returns 1 if a result is due
	function automatic bit predict_centroid(input row_t r, output outcome_t o);
		bit sel_ok, elem_ok;
		int unsigned a, w, best;
		longint unsigned cv, old, bd, du;
		longint acc;
		sel_ok = r.sel < m_active;
		elem_ok = 1'b1;
		o = '0;
		case (r.req)
			REQ_LOAD: begin
				if (!sel_ok) return 0;
				cv = r.cval;
				if (cv > ONE_Q16) cv = ONE_Q16;
				a = r.sel * DBITS + r.elem;
				old = m_cent[a];
				m_norm[r.sel] = m_norm[r.sel] - old*old + cv*cv;
				m_cent[a] = cv[16:0];
				return 0;
			end
			REQ_WORD: begin
				w = m_wcnt;
				m_desc[w] = r.word;
				for (int j = 0; j < NUM_CL; j++) begin
					acc = (w == 0) ? longint'(m_norm[j]) : m_part[j];
					for (int p = 0; p < 64; p++)
						if (r.word[63-p])
							acc += 64'sd4294967296 - longint'(m_cent[j*DBITS + w*64 + p]) * 131072;
					m_part[j] = acc;
				end
				if (w + 1 < WORDS) begin
					m_wcnt = w + 1;
					return 0;
				end
				m_wcnt = 0;
				best = 0; bd = 0;
				for (int j = 0; j < m_active; j++) begin
					du = (m_part[j] < 0) ? 0 : longint'(m_part[j]);
					if (du > DMAX) du = DMAX;
					if (j == 0 || du < bd) begin
						best = j; bd = du;
					end
				end
				for (int p = 0; p < DBITS; p++)
					if (m_desc[p/64][63-(p%64)] && m_bsum[best*DBITS+p] != SUM_MAX)
						m_bsum[best*DBITS+p]++;
				if (m_cnt[best] != SUM_MAX) m_cnt[best]++;
				o.kind = KIND_ASSIGN; o.idx = 4'(best); o.dsq = 41'(bd);
				return 1;
			end
			REQ_RSUM: begin
				if (!sel_ok || !elem_ok) return 0;
				o.kind = KIND_SUM; o.idx = r.sel; o.val = m_bsum[r.sel*DBITS + r.elem];
				return 1;
			end
			REQ_RCNT: begin
				if (!sel_ok) return 0;
				o.kind = KIND_COUNT; o.idx = r.sel; o.val = m_cnt[r.sel];
				return 1;
			end
			REQ_CLEAR: begin
				for (int i = 0; i < NUM_CL*DBITS; i++) m_bsum[i] = '0;
				for (int i = 0; i < NUM_CL; i++) m_cnt[i] = '0;
				return 0;
			end
			default: return 0;
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && result_valid) begin
			n_res++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result kind=%0d idx=%0d dist=%0d val=%0d",
					$time, result_kind, cluster_index, distance, read_value);
			end else begin
				e = pending_results.pop_front();
				if (result_kind !== e.kind) begin
					errors++;
					$display("%0t: kind expected %0d actual %0d", $time, e.kind, result_kind);
				end
				if (cluster_index !== e.idx) begin
					errors++;
					$display("%0t: cluster expected %0d actual %0d", $time, e.idx, cluster_index);
				end
				if (distance !== e.dsq) begin
					errors++;
					$display("%0t: distance expected %0d actual %0d", $time, e.dsq, distance);
				end
				if (read_value !== e.val) begin
					errors++;
					$display("%0t: value expected %0d actual %0d", $time, e.val, read_value);
				end
			end
		end
	end

	// start stays high across back-to-back requests, drops only when idling
	task automatic send_request(input row_t r);
		outcome_t o;
		bit due;
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= r.req; cluster_sel <= r.sel; elem_index <= r.elem;
		centroid_value <= r.cval; tx_word <= r.word;
		do @(posedge clk); while (busy);
		n_req++;
		due = predict_centroid(r, o);
		if (r.has_fixed && due && o != r.fixed) begin
			errors++;
			$display("%0t: table row expected %h predictor %h", $time, r.fixed, o);
		end
		if (due) begin
			if (r.has_fixed) pending_results.push_back(r.fixed);
			else pending_results.push_back(o);
			if (o.kind == KIND_ASSIGN) n_assign++;
		end
	endtask

	task automatic settle();
		int guard;
		guard = 0;
		start <= 1'b0;
		while (pending_results.size() != 0 && guard < 100000) begin
			@(posedge clk); guard++;
		end
		repeat (40) @(posedge clk);
	endtask

	task automatic write_active(input logic [4:0] v);
		settle();
		cfg_wr_en <= 1'b1; cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		model_cfg(v);
	endtask

	function automatic row_t mk(logic [2:0] q, logic [3:0] s, logic [7:0] el,
			logic [16:0] c, logic [63:0] w);
		row_t r;
		r.req = q; r.sel = s; r.elem = el; r.cval = c; r.word = w;
		r.has_fixed = 0; r.fixed = '0;
		return r;
	endfunction

	function automatic row_t mkx(row_t r, logic [1:0] k, logic [3:0] i,
			logic [40:0] d, logic [23:0] v);
		r.has_fixed = 1; r.fixed = '{kind: k, idx: i, dsq: d, val: v};
		return r;
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic row_t random_row();
		int pick;
		row_t r;
		pick = $urandom_range(0, 99);
		r = mk(REQ_WORD, 4'($urandom()), 8'($urandom()), 17'($urandom()), rnd64());
		if (pick < 20) begin
			r.req = REQ_LOAD;
			case ($urandom_range(0, 3))
				0: r.cval = ONE_Q16;
				1: r.cval = 17'h1FFFF;
				2: r.cval = '0;
				default: r.cval = 17'($urandom_range(0, 65536));
			endcase
		end else if (pick < 70) begin
			case ($urandom_range(0, 3))
				0: r.word = '0;
				1: r.word = '1;
				default: ;
			endcase
		end else if (pick < 82) r.req = REQ_RSUM;
		else if (pick < 92) r.req = REQ_RCNT;
		else if (pick < 94) r.req = REQ_CLEAR;
		else r.req = 3'($urandom_range(5, 7));
		return r;
	endfunction

	initial begin
		row_t tbl[$];
		logic [4:0] phase_cfg [4] = '{5'd1, 5'd0, 5'd31, 5'd16};
		start = 0; req_type = '0; cluster_sel = '0; elem_index = '0;
		centroid_value = '0; tx_word = '0; cfg_wr_en = 0; cfg_wr_data = '0;
		arst_n = 0;
		model_reset();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed table
		tbl.push_back(mkx(mk(REQ_RCNT, 15, 0, 0, 0), KIND_COUNT, 15, 0, 0));
		tbl.push_back(mkx(mk(REQ_RSUM, 0, 255, 0, 0), KIND_SUM, 0, 0, 0));
		for (int i = 0; i < 4; i++)
			tbl.push_back(i == 3 ? mkx(mk(REQ_WORD, 0, 0, 0, '1), KIND_ASSIGN, 0,
				41'd1099511627776, 0) : mk(REQ_WORD, 0, 0, 0, '1));
		tbl.push_back(mk(REQ_LOAD, 3, 0, 17'h1FFFF, 0));
		tbl.push_back(mk(REQ_LOAD, 3, 255, ONE_Q16, 0));
		tbl.push_back(mk(REQ_LOAD, 5, 128, 17'd32768, 0));
		tbl.push_back(mk(REQ_LOAD, 3, 0, 17'd1, 0));
		for (int i = 0; i < 4; i++)
			tbl.push_back(mk(REQ_WORD, 0, 0, 0, i == 0 ? 64'h8000_0000_0000_0000 : 64'h1));
		tbl.push_back(mkx(mk(REQ_RCNT, 0, 0, 0, 0), KIND_COUNT, 0, 0, 1));
		tbl.push_back(mk(REQ_RSUM, 3, 255, 0, 0));
		tbl.push_back(mk(REQ_RCNT, 3, 0, 0, 0));
		tbl.push_back(mk(3'd5, 0, 0, 0, 0));
		tbl.push_back(mk(3'd7, 15, 255, 17'h1FFFF, '1));
		tbl.push_back(mk(REQ_CLEAR, 0, 0, 0, 0));
		tbl.push_back(mkx(mk(REQ_RCNT, 0, 0, 0, 0), KIND_COUNT, 0, 0, 0));
		foreach (tbl[i]) send_request(tbl[i]);

		// inactive cluster reads and loads are dropped
		write_active(5'd2);
		send_request(mk(REQ_RCNT, 2, 0, 0, 0));
		send_request(mk(REQ_LOAD, 15, 7, 17'd100, 0));
		send_request(mkx(mk(REQ_RCNT, 1, 0, 0, 0), KIND_COUNT, 1, 0, 0));

		// random phases across register settings
		for (int ph = 0; ph < 5; ph++) begin
			write_active(ph < 4 ? phase_cfg[ph] : 5'($urandom_range(1, 16)));
			repeat (290) send_request(random_row());
		end

		settle();
		$display("Sent %0d requests, checked %0d results (%0d assignments)",
			n_req, n_res, n_assign);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
